// ----- hw/rtl/wds_pkg.sv -----
// Package: types, codes and reset values for the widget discovery sequencer.
`timescale 1ns / 1ps

package wds_pkg;

  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned VERSION_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 16'd200;
  localparam logic [VERSION_W-1:0]  DUAL_A_RESET    = 8'd2;
  localparam logic [VERSION_W-1:0]  DUAL_B_RESET    = 8'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_B   = 2'd2;

  // command codes
  localparam logic [3:0] CMD_START   = 4'd0;
  localparam logic [3:0] CMD_TICK    = 4'd1;
  localparam logic [3:0] CMD_MANUF   = 4'd2;
  localparam logic [3:0] CMD_DEVICE  = 4'd3;
  localparam logic [3:0] CMD_SERIAL  = 4'd4;
  localparam logic [3:0] CMD_PARAMS  = 4'd5;
  localparam logic [3:0] CMD_HW      = 4'd6;
  localparam logic [3:0] CMD_SNIFFER = 4'd7;
  localparam logic [3:0] CMD_REMOVED = 4'd8;

  // request codes
  localparam logic [2:0] REQ_NONE   = 3'd0;
  localparam logic [2:0] REQ_MANUF  = 3'd1;
  localparam logic [2:0] REQ_DEVICE = 3'd2;
  localparam logic [2:0] REQ_SERIAL = 3'd3;
  localparam logic [2:0] REQ_PARAMS = 3'd4;
  localparam logic [2:0] REQ_HW     = 3'd5;
  localparam logic [2:0] REQ_KEY    = 3'd6;

  // outcome codes
  localparam logic [1:0] OUT_PENDING = 2'd0;
  localparam logic [1:0] OUT_SUCCESS = 2'd1;
  localparam logic [1:0] OUT_FAILED  = 2'd2;
  localparam logic [1:0] OUT_SNIFFER = 2'd3;

  localparam logic [1:0] SNIFFER_MAX = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_MANUF  = 3'd1,
    PH_DEVICE = 3'd2,
    PH_SERIAL = 3'd3,
    PH_PARAMS = 3'd4,
    PH_HW     = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [INTERVAL_W-1:0]  wait_timer;
    logic [15:0]            vendor;
    logic [15:0]            product;
    logic [31:0]            serial;
    logic                   fw_valid;
    logic [15:0]            firmware;
    logic                   dual;
    logic [1:0]             sniffer_count;
  } seq_state_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval_ticks;
    logic [VERSION_W-1:0]  dual_version_a;
    logic [VERSION_W-1:0]  dual_version_b;
  } seq_cfg_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [9:0]  payload_length;
    logic [15:0] id_value;
    logic [31:0] serial_value;
    logic [15:0] firmware_value;
    logic [7:0]  hw_version;
  } seq_item_t;

  // packed so that request sits in the lowest bits
  typedef struct packed {
    logic        twin_port;
    logic [15:0] firmware_out;
    logic        has_firmware;
    logic [31:0] serial_out;
    logic [15:0] product_id;
    logic [15:0] vendor_id;
    logic [1:0]  outcome;
    logic [2:0]  request;
  } seq_result_t;

endpackage

// ----- hw/rtl/widget_discovery_sequencer.sv -----
// Top level: discovery sequencer with stream ports and configuration registers.
// A result is registered onto the master side in the cycle after its event is accepted.
// Throughput: one event per cycle unless m_tready stalls it; the single output register
// refills in the cycle it drains, fed by combinational next-state logic in wds_step.
// Reset (rst, synchronous): idle phase, captured values and sniffer count cleared,
// registers at interval 200 and dual-port codes 2 and 3, no result held.
`timescale 1ns / 1ps

module widget_discovery_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // payload_length, id_value, serial_value, firmware_value, hw_version, zero pad
  input  logic [wds_pkg::IN_DATA_W-1:0]      s_tdata,
  // command
  input  logic [wds_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // request, outcome, vendor_id, product_id, serial_out, has_firmware,
  // firmware_out, twin_port, zero pad
  output logic [wds_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wds_pkg::seq_cfg_t    cfg;
  wds_pkg::seq_state_t  st;
  wds_pkg::seq_state_t  st_next;
  wds_pkg::seq_item_t   item;
  wds_pkg::seq_result_t res_next;
  wds_pkg::seq_result_t res;
  logic                 in_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;

  assign item.command        = s_tuser[3:0];
  assign item.payload_length = s_tdata[9:0];
  assign item.id_value       = s_tdata[25:10];
  assign item.serial_value   = s_tdata[57:26];
  assign item.firmware_value = s_tdata[73:58];
  assign item.hw_version     = s_tdata[81:74];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_ticks <= wds_pkg::INTERVAL_RESET;
      cfg.dual_version_a <= wds_pkg::DUAL_A_RESET;
      cfg.dual_version_b <= wds_pkg::DUAL_B_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == wds_pkg::REG_INTERVAL) begin
        cfg.interval_ticks <= cfg_data;
      end
      if (cfg_index == wds_pkg::REG_DUAL_A) begin
        cfg.dual_version_a <= cfg_data[wds_pkg::VERSION_W-1:0];
      end
      if (cfg_index == wds_pkg::REG_DUAL_B) begin
        cfg.dual_version_b <= cfg_data[wds_pkg::VERSION_W-1:0];
      end
    end
  end

  wds_step u_step (
    .cur  (st),
    .cfg  (cfg),
    .item (item),
    .nxt  (st_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= wds_pkg::PH_IDLE;
      st.wait_timer    <= '0;
      st.vendor        <= '0;
      st.product       <= '0;
      st.serial        <= '0;
      st.fw_valid      <= 1'b0;
      st.firmware      <= '0;
      st.dual          <= 1'b0;
      st.sniffer_count <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = {1'b0, res};

  // no timer runs while idle
  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (st.phase == wds_pkg::PH_IDLE) |-> (st.wait_timer == '0))
    else $error("timer running in idle phase");

  // a start transaction always yields a manufacturer request and clears the sniffer count
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_tuser[3:0] == wds_pkg::CMD_START)) |=>
    (m_tvalid && (res.request == wds_pkg::REQ_MANUF) && (st.phase == wds_pkg::PH_MANUF) &&
     (st.sniffer_count == '0)))
    else $error("start did not restart discovery");

  // an outcome other than pending always leaves the sequencer idle
  a_outcome_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (res_next.outcome != wds_pkg::OUT_PENDING)) |=>
    (st.phase == wds_pkg::PH_IDLE))
    else $error("outcome reported while still running");

  // the output register never blocks input when empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule

// ----- hw/rtl/wds_step.sv -----
// Next-state and result logic for one discovery event.
`timescale 1ns / 1ps

module wds_step (
  input  wds_pkg::seq_state_t  cur,
  input  wds_pkg::seq_cfg_t    cfg,
  input  wds_pkg::seq_item_t   item,
  output wds_pkg::seq_state_t  nxt,
  output wds_pkg::seq_result_t res
);

  logic       running;
  logic       need_hw;
  logic       timed_out;
  logic [2:0] req;
  logic [1:0] outc;
  logic [1:0] done_code;

  assign running   = (cur.phase != wds_pkg::PH_IDLE);
  assign need_hw   = (cur.vendor == 16'd0) && (cur.product == 16'd0);
  assign timed_out = (cur.wait_timer <= 16'd1);
  assign done_code = (cur.sniffer_count > 2'd1) ? wds_pkg::OUT_SNIFFER : wds_pkg::OUT_SUCCESS;

  always_comb begin
    nxt  = cur;
    req  = wds_pkg::REQ_NONE;
    outc = wds_pkg::OUT_PENDING;
    if (item.command == wds_pkg::CMD_START) begin
      nxt.vendor        = '0;
      nxt.product       = '0;
      nxt.serial        = '0;
      nxt.fw_valid      = 1'b0;
      nxt.firmware      = '0;
      nxt.dual          = 1'b0;
      nxt.sniffer_count = '0;
      nxt.phase         = wds_pkg::PH_MANUF;
      nxt.wait_timer    = cfg.interval_ticks;
      req               = wds_pkg::REQ_MANUF;
    end else if (running) begin
      unique case (item.command)
        wds_pkg::CMD_TICK: begin
          if (timed_out) begin
            unique case (cur.phase)
              wds_pkg::PH_MANUF: begin
                req            = wds_pkg::REQ_DEVICE;
                nxt.phase      = wds_pkg::PH_DEVICE;
                nxt.wait_timer = cfg.interval_ticks;
              end
              wds_pkg::PH_DEVICE: begin
                req            = wds_pkg::REQ_SERIAL;
                nxt.phase      = wds_pkg::PH_SERIAL;
                nxt.wait_timer = cfg.interval_ticks;
              end
              wds_pkg::PH_PARAMS: begin
                if (need_hw) begin
                  req            = wds_pkg::REQ_HW;
                  nxt.phase      = wds_pkg::PH_HW;
                  nxt.wait_timer = cfg.interval_ticks;
                end else begin
                  outc           = done_code;
                  nxt.phase      = wds_pkg::PH_IDLE;
                  nxt.wait_timer = '0;
                end
              end
              wds_pkg::PH_HW: begin
                outc           = done_code;
                nxt.phase      = wds_pkg::PH_IDLE;
                nxt.wait_timer = '0;
              end
              default: begin
                outc           = wds_pkg::OUT_FAILED;
                nxt.phase      = wds_pkg::PH_IDLE;
                nxt.wait_timer = '0;
              end
            endcase
          end else begin
            nxt.wait_timer = cur.wait_timer - 16'd1;
          end
        end
        wds_pkg::CMD_MANUF: begin
          if (item.payload_length >= 10'd2) begin
            nxt.vendor = item.id_value;
            if (cur.phase == wds_pkg::PH_MANUF) begin
              req            = wds_pkg::REQ_DEVICE;
              nxt.phase      = wds_pkg::PH_DEVICE;
              nxt.wait_timer = cfg.interval_ticks;
            end
          end
        end
        wds_pkg::CMD_DEVICE: begin
          if (item.payload_length >= 10'd2) begin
            nxt.product = item.id_value;
            if (cur.phase == wds_pkg::PH_DEVICE) begin
              req            = wds_pkg::REQ_SERIAL;
              nxt.phase      = wds_pkg::PH_SERIAL;
              nxt.wait_timer = cfg.interval_ticks;
            end
          end
        end
        wds_pkg::CMD_SERIAL: begin
          if (item.payload_length == 10'd4) begin
            nxt.serial = item.serial_value;
          end
          req            = wds_pkg::REQ_PARAMS;
          nxt.phase      = wds_pkg::PH_PARAMS;
          nxt.wait_timer = cfg.interval_ticks;
        end
        wds_pkg::CMD_PARAMS: begin
          if (item.payload_length >= 10'd5) begin
            nxt.fw_valid = 1'b1;
            nxt.firmware = item.firmware_value;
          end
          if (need_hw) begin
            req            = wds_pkg::REQ_HW;
            nxt.phase      = wds_pkg::PH_HW;
            nxt.wait_timer = cfg.interval_ticks;
          end else begin
            outc           = done_code;
            nxt.phase      = wds_pkg::PH_IDLE;
            nxt.wait_timer = '0;
          end
        end
        wds_pkg::CMD_HW: begin
          if (item.payload_length == 10'd1) begin
            if ((item.hw_version == cfg.dual_version_a) ||
                (item.hw_version == cfg.dual_version_b)) begin
              nxt.dual = 1'b1;
              req      = wds_pkg::REQ_KEY;
            end
            outc           = done_code;
            nxt.phase      = wds_pkg::PH_IDLE;
            nxt.wait_timer = '0;
          end
        end
        wds_pkg::CMD_SNIFFER: begin
          if (cur.sniffer_count != wds_pkg::SNIFFER_MAX) begin
            nxt.sniffer_count = cur.sniffer_count + 2'd1;
          end
        end
        wds_pkg::CMD_REMOVED: begin
          outc           = wds_pkg::OUT_FAILED;
          nxt.phase      = wds_pkg::PH_IDLE;
          nxt.wait_timer = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.request      = req;
    res.outcome      = outc;
    res.vendor_id    = nxt.vendor;
    res.product_id   = nxt.product;
    res.serial_out   = nxt.serial;
    res.has_firmware = nxt.fw_valid;
    res.firmware_out = nxt.firmware;
    res.twin_port    = nxt.dual;
  end

endmodule

// ----- tb/sv/widget_discovery_sequencer_tb.sv -----
// Testbench: self-checking stream-level test of the widget discovery sequencer.
`timescale 1ns / 1ps

module widget_discovery_sequencer_tb;

  localparam logic [wds_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [3:0] CMD_OTHER = 4'd9;
  localparam logic [3:0] CMD_TOP = 4'd15;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned STEPS_PER_RUN = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [wds_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [wds_pkg::IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [wds_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  widget_discovery_sequencer uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted sequencer state and registers
  wds_pkg::phase_t ph;
  logic [15:0] wait_ticks;
  logic [15:0] cap_vendor;
  logic [15:0] cap_product;
  logic [31:0] cap_serial;
  logic cap_fw_valid;
  logic [15:0] cap_fw;
  logic cap_dual;
  logic [1:0] sniff_cnt;
  logic [15:0] cfg_interval;
  logic [7:0] cfg_dual_a;
  logic [7:0] cfg_dual_b;
  logic [2:0] step_req;
  logic [1:0] step_out;

  wds_pkg::seq_result_t result_q[$];
  int unsigned mismatches = 0;
  bit steady = 1'b0;

  function automatic void reset_predictor();
    ph = wds_pkg::PH_IDLE;
    wait_ticks = '0;
    cap_vendor = '0;
    cap_product = '0;
    cap_serial = '0;
    cap_fw_valid = 1'b0;
    cap_fw = '0;
    cap_dual = 1'b0;
    sniff_cnt = '0;
    cfg_interval = wds_pkg::INTERVAL_RESET;
    cfg_dual_a = wds_pkg::DUAL_A_RESET;
    cfg_dual_b = wds_pkg::DUAL_B_RESET;
  endfunction

  function automatic void send_request(logic [2:0] req, wds_pkg::phase_t nxt);
    step_req = req;
    ph = nxt;
    wait_ticks = cfg_interval;
  endfunction

  function automatic void conclude();
    step_out = (sniff_cnt > 2'd1) ? wds_pkg::OUT_SNIFFER : wds_pkg::OUT_SUCCESS;
    ph = wds_pkg::PH_IDLE;
    wait_ticks = '0;
  endfunction

  function automatic void abort_run();
    step_out = wds_pkg::OUT_FAILED;
    ph = wds_pkg::PH_IDLE;
    wait_ticks = '0;
  endfunction

  function automatic void params_answered();
    if (cap_vendor == '0 && cap_product == '0) send_request(wds_pkg::REQ_HW, wds_pkg::PH_HW);
    else conclude();
  endfunction

  function automatic void response_timeout();
    case (ph)
      wds_pkg::PH_MANUF: send_request(wds_pkg::REQ_DEVICE, wds_pkg::PH_DEVICE);
      wds_pkg::PH_DEVICE: send_request(wds_pkg::REQ_SERIAL, wds_pkg::PH_SERIAL);
      wds_pkg::PH_PARAMS: params_answered();
      wds_pkg::PH_HW: conclude();
      default: abort_run();
    endcase
  endfunction

  function automatic wds_pkg::seq_result_t discovery_step(wds_pkg::seq_item_t ev);
    wds_pkg::seq_result_t r;
    bit running;
    running = (ph != wds_pkg::PH_IDLE);
    step_req = wds_pkg::REQ_NONE;
    step_out = wds_pkg::OUT_PENDING;
    if (ev.command == wds_pkg::CMD_START) begin
      cap_vendor = '0;
      cap_product = '0;
      cap_serial = '0;
      cap_fw_valid = 1'b0;
      cap_fw = '0;
      cap_dual = 1'b0;
      sniff_cnt = '0;
      send_request(wds_pkg::REQ_MANUF, wds_pkg::PH_MANUF);
    end else if (running) begin
      case (ev.command)
        wds_pkg::CMD_TICK: begin
          if (wait_ticks <= 16'd1) response_timeout();
          else wait_ticks = wait_ticks - 16'd1;
        end
        wds_pkg::CMD_MANUF: begin
          if (ev.payload_length >= 10'd2) begin
            cap_vendor = ev.id_value;
            if (ph == wds_pkg::PH_MANUF)
              send_request(wds_pkg::REQ_DEVICE, wds_pkg::PH_DEVICE);
          end
        end
        wds_pkg::CMD_DEVICE: begin
          if (ev.payload_length >= 10'd2) begin
            cap_product = ev.id_value;
            if (ph == wds_pkg::PH_DEVICE)
              send_request(wds_pkg::REQ_SERIAL, wds_pkg::PH_SERIAL);
          end
        end
        wds_pkg::CMD_SERIAL: begin
          if (ev.payload_length == 10'd4) cap_serial = ev.serial_value;
          send_request(wds_pkg::REQ_PARAMS, wds_pkg::PH_PARAMS);
        end
        wds_pkg::CMD_PARAMS: begin
          if (ev.payload_length >= 10'd5) begin
            cap_fw_valid = 1'b1;
            cap_fw = ev.firmware_value;
          end
          params_answered();
        end
        wds_pkg::CMD_HW: begin
          if (ev.payload_length == 10'd1) begin
            if (ev.hw_version == cfg_dual_a || ev.hw_version == cfg_dual_b) begin
              cap_dual = 1'b1;
              step_req = wds_pkg::REQ_KEY;
            end
            conclude();
          end
        end
        wds_pkg::CMD_SNIFFER:
          if (sniff_cnt < wds_pkg::SNIFFER_MAX) sniff_cnt = sniff_cnt + 2'd1;
        wds_pkg::CMD_REMOVED: abort_run();
        default: ;
      endcase
    end
    r.request = step_req;
    r.outcome = step_out;
    r.vendor_id = cap_vendor;
    r.product_id = cap_product;
    r.serial_out = cap_serial;
    r.has_firmware = cap_fw_valid;
    r.firmware_out = cap_fw;
    r.twin_port = cap_dual;
    return r;
  endfunction

  function automatic wds_pkg::seq_item_t ev_of(logic [3:0] cmd, logic [9:0] len,
                                               logic [15:0] idv, logic [31:0] ser,
                                               logic [15:0] fw, logic [7:0] hw);
    wds_pkg::seq_item_t ev;
    ev.command = cmd;
    ev.payload_length = len;
    ev.id_value = idv;
    ev.serial_value = ser;
    ev.firmware_value = fw;
    ev.hw_version = hw;
    return ev;
  endfunction

  // mostly back to back, sometimes short pauses, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_event(input wds_pkg::seq_item_t ev);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ev.command;
    s_tdata <= {{(wds_pkg::IN_DATA_W - 82){1'b0}}, ev.hw_version, ev.firmware_value,
                ev.serial_value, ev.id_value, ev.payload_length};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    result_q.push_back(discovery_step(ev));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [wds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wds_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      wds_pkg::REG_INTERVAL: cfg_interval = val;
      wds_pkg::REG_DUAL_A: cfg_dual_a = val[7:0];
      wds_pkg::REG_DUAL_B: cfg_dual_b = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] interval, input logic [7:0] code_a,
                               input logic [7:0] code_b);
    wait_idle();
    cfg_write(wds_pkg::REG_INTERVAL, interval);
    cfg_write(wds_pkg::REG_DUAL_A, {8'd0, code_a});
    cfg_write(wds_pkg::REG_DUAL_B, {8'd0, code_b});
  endtask

  function automatic logic [9:0] fuzz_len(logic [9:0] good);
    if ($urandom_range(0, 99) < 15) return 10'($urandom_range(0, 600));
    return good;
  endfunction

  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 99) < 35) return '0;
    return 16'($urandom_range(0, 65535));
  endfunction

  // weighted towards the answer the current phase is waiting for
  function automatic wds_pkg::seq_item_t next_event();
    wds_pkg::seq_item_t ev;
    int unsigned r;
    int unsigned h;
    ev = ev_of(wds_pkg::CMD_TICK, 10'($urandom_range(0, 600)),
               16'($urandom_range(0, 65535)), 32'($urandom),
               16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 55) begin
      case (ph)
        wds_pkg::PH_MANUF: begin
          ev.command = wds_pkg::CMD_MANUF;
          ev.payload_length = fuzz_len(10'd2);
          ev.id_value = pick_id();
        end
        wds_pkg::PH_DEVICE: begin
          ev.command = wds_pkg::CMD_DEVICE;
          ev.payload_length = fuzz_len(10'd2);
          ev.id_value = pick_id();
        end
        wds_pkg::PH_SERIAL: begin
          ev.command = wds_pkg::CMD_SERIAL;
          ev.payload_length = fuzz_len(10'd4);
        end
        wds_pkg::PH_PARAMS: begin
          ev.command = wds_pkg::CMD_PARAMS;
          ev.payload_length = fuzz_len(10'($urandom_range(5, 8)));
        end
        default: begin
          ev.command = wds_pkg::CMD_HW;
          ev.payload_length = fuzz_len(10'd1);
          h = $urandom_range(0, 99);
          if (h < 40) ev.hw_version = cfg_dual_a;
          else if (h < 70) ev.hw_version = cfg_dual_b;
        end
      endcase
    end else if (r < 75) begin
      ev.command = wds_pkg::CMD_TICK;
    end else if (r < 83) begin
      ev.command = wds_pkg::CMD_SNIFFER;
    end else if (r < 88) begin
      ev.command = 4'($urandom_range(wds_pkg::CMD_MANUF, wds_pkg::CMD_HW));
      ev.payload_length = 10'($urandom_range(0, 6));
    end else if (r < 90) begin
      ev.command = wds_pkg::CMD_REMOVED;
    end else if (r < 92) begin
      ev.command = wds_pkg::CMD_START;
    end else if (r < 94) begin
      ev.command = 4'($urandom_range(CMD_OTHER, CMD_TOP));
    end else begin
      ev.command = 4'($urandom_range(0, 15));
    end
    return ev;
  endfunction

  task automatic run_random_discoveries(input int unsigned n_items);
    int unsigned sent;
    int unsigned steps;
    wds_pkg::seq_item_t ev;
    sent = 0;
    while (sent < n_items) begin
      steady = ($urandom_range(0, 99) < 15);
      send_event(ev_of(wds_pkg::CMD_START, 10'($urandom_range(0, 600)),
                       16'($urandom_range(0, 65535)), 32'($urandom),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
      sent++;
      steps = 0;
      while (ph != wds_pkg::PH_IDLE && steps < STEPS_PER_RUN) begin
        send_event(next_event());
        sent++;
        steps++;
      end
      // noise while idle, which leaves the block's state unchanged
      if (ph == wds_pkg::PH_IDLE && $urandom_range(0, 99) < 20) begin
        ev = next_event();
        if (ev.command != wds_pkg::CMD_START) send_event(ev);
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_directed_defaults();
    send_event(ev_of(wds_pkg::CMD_TICK, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_MANUF, 10'd2, 16'hFFFF, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_REMOVED, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_SNIFFER, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_START, 10'd600, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    send_event(ev_of(wds_pkg::CMD_MANUF, 10'd1, 16'h1234, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_MANUF, 10'd2, 16'hFFFF, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_MANUF, 10'd600, 16'h5A5A, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_DEVICE, 10'd2, 16'h0000, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_SERIAL, 10'd3, 16'd0, 32'hDEAD_BEEF, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_PARAMS, 10'd4, 16'd0, 32'd0, 16'hABCD, 8'd0));
    // sniffer count saturates, then removal while running
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    repeat (4) send_event(ev_of(wds_pkg::CMD_SNIFFER, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_REMOVED, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    // no ids captured: hardware version path, dual-port code
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_MANUF, 10'd2, 16'h0000, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_DEVICE, 10'd2, 16'h0000, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_SERIAL, 10'd4, 16'd0, 32'hFFFF_FFFF, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_PARAMS, 10'd5, 16'd0, 32'd0, 16'hFFFF, 8'd0));
    send_event(ev_of(wds_pkg::CMD_HW, 10'd2, 16'd0, 32'd0, 16'd0, wds_pkg::DUAL_B_RESET));
    send_event(ev_of(wds_pkg::CMD_HW, 10'd1, 16'd0, 32'd0, 16'd0, wds_pkg::DUAL_B_RESET));
    // restart mid-run, unknown commands, sniffer rejection
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(CMD_TOP, 10'd600, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    send_event(ev_of(CMD_OTHER, 10'd2, 16'h1111, 32'd1, 16'd1, 8'd1));
    repeat (2) send_event(ev_of(wds_pkg::CMD_SNIFFER, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_PARAMS, 10'd5, 16'd0, 32'd0, 16'h0000, 8'd0));
    send_event(ev_of(wds_pkg::CMD_HW, 10'd1, 16'd0, 32'd0, 16'd0, 8'hFF));
  endtask

  task automatic test_timeouts();
    apply_setting(16'd1, wds_pkg::DUAL_A_RESET, wds_pkg::DUAL_B_RESET);
    cfg_write(REG_SPARE, 16'hFFFF);
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    repeat (3) send_event(ev_of(wds_pkg::CMD_TICK, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    repeat (2) send_event(ev_of(wds_pkg::CMD_TICK, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_SERIAL, 10'd4, 16'd0, 32'h0123_4567, 16'd0, 8'd0));
    repeat (2) send_event(ev_of(wds_pkg::CMD_TICK, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    apply_setting(16'd2, 8'd0, 8'd255);
    send_event(ev_of(wds_pkg::CMD_START, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_MANUF, 10'd2, 16'h0042, 32'd0, 16'd0, 8'd0));
    repeat (3) send_event(ev_of(wds_pkg::CMD_TICK, 10'd0, 16'd0, 32'd0, 16'd0, 8'd0));
    send_event(ev_of(wds_pkg::CMD_PARAMS, 10'd5, 16'd0, 32'd0, 16'h0102, 8'd0));
  endtask

  task automatic test_random_settings();
    apply_setting(16'd3, wds_pkg::DUAL_A_RESET, wds_pkg::DUAL_B_RESET);
    run_random_discoveries(260);
    apply_setting(16'd1, 8'd0, 8'd255);
    run_random_discoveries(260);
    apply_setting(16'hFFFF, 8'd255, 8'd0);
    run_random_discoveries(220);
    apply_setting(16'd5, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random_discoveries(260);
    apply_setting(wds_pkg::INTERVAL_RESET, wds_pkg::DUAL_A_RESET, wds_pkg::DUAL_B_RESET);
    run_random_discoveries(240);
    apply_setting(16'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random_discoveries(260);
  endtask

  // receiver stalls
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  wds_pkg::seq_result_t got_res;
  wds_pkg::seq_result_t want_res;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = m_tdata[$bits(wds_pkg::seq_result_t)-1:0];
      if (result_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, got_res);
        mismatches++;
      end else begin
        want_res = result_q.pop_front();
        check_field("request", want_res.request, got_res.request);
        check_field("outcome", want_res.outcome, got_res.outcome);
        check_field("vendor_id", want_res.vendor_id, got_res.vendor_id);
        check_field("product_id", want_res.product_id, got_res.product_id);
        check_field("serial_out", want_res.serial_out, got_res.serial_out);
        check_field("has_firmware", want_res.has_firmware, got_res.has_firmware);
        check_field("firmware_out", want_res.firmware_out, got_res.firmware_out);
        check_field("twin_port", want_res.twin_port, got_res.twin_port);
      end
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_predictor();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_timeouts();
    test_random_settings();
    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/wds_pkg.sv
hw/rtl/wds_step.sv
hw/rtl/widget_discovery_sequencer.sv
tb/sv/widget_discovery_sequencer_tb.sv
